[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the quaternion rotation RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define QVR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("qvr assertion failed");

// next-cycle implication, disabled while reset is asserted
`define QVR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("qvr assertion failed");

`endif

[rtl/qvr_pkg.sv]
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths, payload types and codes of the quaternion vector rotation block.
// ----------------------------------------------------------------------------
package qvr_pkg;

	// field widths
	localparam int VEC_W  = 24;
	localparam int QUAT_W = 16;
	localparam int FRAC_W = QUAT_W - 2;

	// internal widths: quaternion product, exact matrix entry, rounded entry,
	// lane term, three-term sum, rounded sum
	localparam int PROD_W = 2 * QUAT_W;
	localparam int MAT_W  = 2 * QUAT_W + 2;
	localparam int ENT_W  = MAT_W + 1 - FRAC_W;
	localparam int TERM_W = ENT_W + VEC_W;
	localparam int DOT_W  = TERM_W + 2;
	localparam int RND_W  = DOT_W + 1 - FRAC_W;

	// output range
	localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
	localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

	// direction command
	typedef enum logic {
		CMD_TO_EARTH = 1'b0,
		CMD_TO_BODY  = 1'b1
	} cmd_t;

	typedef logic signed [QUAT_W-1:0] quat_t;
	typedef logic signed [VEC_W-1:0]  vec_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ENT_W-1:0]  ent_t;
	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [RND_W-1:0]  rnd_t;

	typedef struct packed {
		cmd_t  command;
		quat_t quat_w;
		quat_t quat_x;
		quat_t quat_y;
		quat_t quat_z;
		vec_t  vec_in_x;
		vec_t  vec_in_y;
		vec_t  vec_in_z;
	} item_t;

	typedef struct packed {
		vec_t vec_out_x;
		vec_t vec_out_y;
		vec_t vec_out_z;
		logic clipped;
	} result_t;

endpackage

[rtl/qvr_matrix.sv]
// ----------------------------------------------------------------------------
// qvr_matrix
// Two-stage rotation matrix builder: quaternion products, then rounded
// entries, transposed per command and sorted into one row per lane.
// ----------------------------------------------------------------------------
module qvr_matrix (
	input  logic                 clk,
	input  logic                 en,
	input  qvr_pkg::item_t       item,
	output qvr_pkg::ent_t        ent_s2 [3][3],
	output qvr_pkg::vec_t        vec_s2 [3]
);

	localparam int MAT_W  = qvr_pkg::MAT_W;
	localparam int FRAC_W = qvr_pkg::FRAC_W;
	localparam logic signed [MAT_W-1:0] FULL   = MAT_W'(1) << (2 * FRAC_W);
	localparam logic signed [MAT_W:0]   HALF_M = (MAT_W + 1)'(1) << (FRAC_W - 1);

	qvr_pkg::prod_t xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	qvr_pkg::cmd_t  cmd_s1;
	qvr_pkg::vec_t  vec_s1 [3];

	logic signed [MAT_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
	logic signed [MAT_W-1:0] m  [3][3];
	logic signed [MAT_W:0]   mr [3][3];
	qvr_pkg::ent_t           e  [3][3];
	qvr_pkg::ent_t           sel [3][3];

	// stage 1: the nine quaternion products
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1  <= item.quat_x * item.quat_x;
			yy_s1  <= item.quat_y * item.quat_y;
			zz_s1  <= item.quat_z * item.quat_z;
			xy_s1  <= item.quat_x * item.quat_y;
			xz_s1  <= item.quat_x * item.quat_z;
			yz_s1  <= item.quat_y * item.quat_z;
			wx_s1  <= item.quat_w * item.quat_x;
			wy_s1  <= item.quat_w * item.quat_y;
			wz_s1  <= item.quat_w * item.quat_z;
			cmd_s1 <= item.command;
			vec_s1[0] <= item.vec_in_x;
			vec_s1[1] <= item.vec_in_y;
			vec_s1[2] <= item.vec_in_z;
		end
	end

	// exact entries with 2F fraction bits
	always_comb begin
		xx = MAT_W'(xx_s1);
		yy = MAT_W'(yy_s1);
		zz = MAT_W'(zz_s1);
		xy = MAT_W'(xy_s1);
		xz = MAT_W'(xz_s1);
		yz = MAT_W'(yz_s1);
		wx = MAT_W'(wx_s1);
		wy = MAT_W'(wy_s1);
		wz = MAT_W'(wz_s1);
		m[0][0] = FULL - ((yy + zz) <<< 1);
		m[0][1] = (xy - wz) <<< 1;
		m[0][2] = (xz + wy) <<< 1;
		m[1][0] = (xy + wz) <<< 1;
		m[1][1] = FULL - ((xx + zz) <<< 1);
		m[1][2] = (yz - wx) <<< 1;
		m[2][0] = (xz - wy) <<< 1;
		m[2][1] = (yz + wx) <<< 1;
		m[2][2] = FULL - ((xx + yy) <<< 1);
	end

	// round half up to F fraction bits, then pick rows or columns per command
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				mr[i][j] = (MAT_W + 1)'(m[i][j]) + HALF_M;
				e[i][j]  = mr[i][j][MAT_W:FRAC_W];
			end
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				unique case (cmd_s1)
					qvr_pkg::CMD_TO_EARTH: sel[i][j] = e[i][j];
					qvr_pkg::CMD_TO_BODY:  sel[i][j] = e[j][i];
					default:               sel[i][j] = e[i][j];
				endcase
			end
		end
	end

	// stage 2: lane rows and the vector
	always_ff @(posedge clk) begin
		if (en) begin
			ent_s2 <= sel;
			vec_s2 <= vec_s1;
		end
	end

endmodule

[rtl/qvr_lane.sv]
// ----------------------------------------------------------------------------
// qvr_lane
// One output component: three entry-by-component products, their sum and
// the rounding back to the vector format.
// ----------------------------------------------------------------------------
module qvr_lane (
	input  logic           clk,
	input  logic           en,
	input  qvr_pkg::ent_t  row [3],
	input  qvr_pkg::vec_t  vec [3],
	output qvr_pkg::rnd_t  rnd_s4
);

	localparam int DOT_W  = qvr_pkg::DOT_W;
	localparam int FRAC_W = qvr_pkg::FRAC_W;
	localparam logic signed [DOT_W:0] HALF_D = (DOT_W + 1)'(1) << (FRAC_W - 1);

	qvr_pkg::term_t          term_s3 [3];
	logic signed [DOT_W-1:0] dot;
	logic signed [DOT_W:0]   dot_r;

	// stage 3: products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				term_s3[j] <= row[j] * vec[j];
			end
		end
	end

	// exact sum and round half up
	always_comb begin
		dot   = DOT_W'(term_s3[0]) + DOT_W'(term_s3[1]) + DOT_W'(term_s3[2]);
		dot_r = (DOT_W + 1)'(dot) + HALF_D;
	end

	// stage 4: rounded component
	always_ff @(posedge clk) begin
		if (en) begin
			rnd_s4 <= dot_r[DOT_W:FRAC_W];
		end
	end

endmodule

[rtl/qvr_merge.sv]
// ----------------------------------------------------------------------------
// qvr_merge
// Merge stage: saturates the three lane results and combines their
// overflow into the clipped flag.
// ----------------------------------------------------------------------------
module qvr_merge (
	input  logic              clk,
	input  logic              en,
	input  qvr_pkg::rnd_t     rnd [3],
	output qvr_pkg::result_t  res_s5
);

	localparam int RND_W = qvr_pkg::RND_W;
	localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(qvr_pkg::VEC_MAX);
	localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(qvr_pkg::VEC_MIN);

	qvr_pkg::vec_t sat [3];
	logic [2:0]    ovf;

	// clamp each lane to the vector range
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			priority if (rnd[i] > SAT_HI) begin
				sat[i] = qvr_pkg::VEC_MAX;
				ovf[i] = 1'b1;
			end else if (rnd[i] < SAT_LO) begin
				sat[i] = qvr_pkg::VEC_MIN;
				ovf[i] = 1'b1;
			end else begin
				sat[i] = rnd[i][qvr_pkg::VEC_W-1:0];
				ovf[i] = 1'b0;
			end
		end
	end

	// stage 5: result register
	always_ff @(posedge clk) begin
		if (en) begin
			res_s5.vec_out_x <= sat[0];
			res_s5.vec_out_y <= sat[1];
			res_s5.vec_out_z <= sat[2];
			res_s5.clipped   <= |ovf;
		end
	end

endmodule

[rtl/quaternion_vector_rotate.sv]
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a fixed-point 3-vector by the direction cosine matrix of a Q1.14
// quaternion, body to earth frame or (transposed) earth to body frame.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid, item_stall, item) carries the command, the
//   quaternion and the vector; result channel (result_valid, result_stall,
//   result) returns the saturated vector and the clipped flag, one result
//   per item, in order. A transfer happens on a rising edge with valid high
//   and stall low.
//   Throughput: one item per cycle while the result channel is not stalled;
//   the pipeline is five register stages
//   (quaternion products, rounded matrix, three lane multiplies, lane sums,
//   saturating merge) with nine multipliers in each of the first and third.
//   A stall on the result channel freezes the whole pipeline; the item
//   channel still takes one more item into a one-entry skid register, and
//   item_stall rises only while that register is full.
//   Reset clears the valid bits and the skid register; no result is pending
//   afterwards. The block holds no state between items.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_vector_rotate (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  qvr_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output qvr_pkg::result_t  result
);

	logic            en;
	logic            skid_q;
	qvr_pkg::item_t  skid_item_q;
	qvr_pkg::item_t  src_item;
	logic            src_valid;
	logic            v_s1, v_s2, v_s3, v_s4, v_s5;

	qvr_pkg::ent_t   ent_s2 [3][3];
	qvr_pkg::vec_t   vec_s2 [3];
	qvr_pkg::rnd_t   rnd_s4 [3];

	// pipeline advances unless a finished result is held back
	assign en         = !(v_s5 && result_stall);
	assign item_stall = skid_q;
	assign src_valid  = skid_q || item_valid;
	assign src_item   = skid_q ? skid_item_q : item;

	// skid register: catches a transfer that arrives while frozen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
		end else if (en) begin
			skid_q <= 1'b0;
		end else if (item_valid && !skid_q) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && item_valid && !skid_q) begin
			skid_item_q <= item;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= src_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// matrix build, stages 1 and 2
	qvr_matrix u_matrix (
		.clk    (clk),
		.en     (en),
		.item   (src_item),
		.ent_s2 (ent_s2),
		.vec_s2 (vec_s2)
	);

	// one lane per output component, stages 3 and 4
	for (genvar i = 0; i < 3; i++) begin : g_lane
		qvr_lane u_lane (
			.clk    (clk),
			.en     (en),
			.row    (ent_s2[i]),
			.vec    (vec_s2),
			.rnd_s4 (rnd_s4[i])
		);
	end

	// saturate and merge, stage 5
	qvr_merge u_merge (
		.clk    (clk),
		.en     (en),
		.rnd    (rnd_s4),
		.res_s5 (result)
	);

	assign result_valid = v_s5;

	// skid fills only while the pipeline is frozen
	`QVR_ASSERT_NOW(a_skid_fill_frozen, clk, arst_n, $rose(skid_q), $past(!en))
	// a held skid entry drains on the first advancing cycle
	`QVR_ASSERT_NEXT(a_skid_drains, clk, arst_n, skid_q && en, !skid_q)
	// an item in the last lane stage reaches the output on advance
	`QVR_ASSERT_NEXT(a_no_drop, clk, arst_n, v_s4 && en, result_valid)
	// clipped implies at least one component sits at a range limit
	`QVR_ASSERT_NOW(a_clip_at_limit, clk, arst_n, result_valid && result.clipped,
		result.vec_out_x == qvr_pkg::VEC_MAX || result.vec_out_x == qvr_pkg::VEC_MIN ||
		result.vec_out_y == qvr_pkg::VEC_MAX || result.vec_out_y == qvr_pkg::VEC_MIN ||
		result.vec_out_z == qvr_pkg::VEC_MAX || result.vec_out_z == qvr_pkg::VEC_MIN)

endmodule
